>>> sv/sle_pkg.sv
// Shared types, character codes and helpers of the serial line editor.
// Used by sle_out and serial_line_editor_echo; depends on nothing.
`default_nettype none

package sle_pkg;

    // Input word kinds.
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // Character codes.
    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    localparam int unsigned LEN_PORT_W = 6;

    // One job for the output stage: up to three echo bytes plus status.
    typedef struct packed {
        logic                  tx_en;     // echo bytes present
        logic [1:0]            cnt;       // number of results, 1 to 3
        logic [2:0][7:0]       echo;      // echo[0] goes out first
        logic                  read_hit;  // read word with index inside the line
        logic                  line_ready;
        logic [LEN_PORT_W-1:0] line_length;
    } out_job_t;

    function automatic logic is_printable(input logic [7:0] b);
        return (b >= CH_SPACE) && (b <= CH_TILDE);
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] b);
        return ((b >= CH_LOW_A) && (b <= CH_LOW_Z)) ? (b - CASE_OFS) : b;
    endfunction

endpackage

`default_nettype wire

>>> sv/sle_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package needed.
`default_nettype none

module sle_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> sv/sle_out.sv
// Output register: holds one job and sends its words one per cycle while out_ready is high.
// Depends on sle_pkg for the job type.
`default_nettype none

module sle_out
    import sle_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       load_valid,
    output logic            load_ready,
    input  wire out_job_t   load_job,
    input  wire logic [7:0] ram_q,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            tx_valid,
    output logic [7:0]      tx_byte,
    output logic            last,
    output logic            line_ready,
    output logic [5:0]      line_length,
    output logic [7:0]      read_data
);

    logic       ob_valid_reg, ob_valid_next;
    logic [1:0] seq_reg, seq_next;
    out_job_t   job_reg;
    logic [7:0] rdata_reg;
    logic       is_last;

    assign is_last    = (seq_reg == (job_reg.cnt - 2'd1));
    assign load_ready = !ob_valid_reg || (out_ready && is_last);

    always_comb
    begin
        ob_valid_next = ob_valid_reg;
        seq_next      = seq_reg;
        if (load_valid && load_ready)
        begin
            ob_valid_next = 1'b1;
            seq_next      = 2'd0;
        end
        else if (ob_valid_reg && out_ready)
        begin
            if (is_last)
            begin
                ob_valid_next = 1'b0;
            end
            else
            begin
                seq_next = seq_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ob_valid_reg <= 1'b0;
            seq_reg      <= 2'd0;
        end
        else
        begin
            ob_valid_reg <= ob_valid_next;
            seq_reg      <= seq_next;
        end
    end

    // The RAM output is sampled here, as the job leaves the pipeline register.
    always_ff @(posedge clk)
    begin
        if (load_valid && load_ready)
        begin
            job_reg   <= load_job;
            rdata_reg <= load_job.read_hit ? ram_q : 8'h00;
        end
    end

    assign out_valid   = ob_valid_reg;
    assign tx_valid    = job_reg.tx_en;
    assign tx_byte     = job_reg.tx_en ? job_reg.echo[seq_reg] : 8'h00;
    assign last        = is_last;
    assign line_ready  = job_reg.line_ready;
    assign line_length = job_reg.line_length;
    assign read_data   = rdata_reg;

endmodule

`default_nettype wire

>>> sv/serial_line_editor_echo.sv
// Serial line editor with echo: an accepted word updates the line state at once,
// writes or reads the line RAM, and passes a job to the output register.
// A job passes the pipeline register, then the output register. One word per
// cycle is taken while each word gives a single result and out_ready is high;
// a word echoing n bytes (n up to 3) holds the output register till all are sent.
// Reset clears the position, length, ready flag, echo mode and all valid flags;
// the line RAM is not cleared.
`default_nettype none

module serial_line_editor_echo
    import sle_pkg::*;
#(
    parameter int unsigned LINE_DEPTH = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_wdata,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] kind,
    input  wire logic [7:0] rx_byte,
    input  wire logic [4:0] read_index,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            tx_valid,
    output logic [7:0]      tx_byte,
    output logic            last,
    output logic            line_ready,
    output logic [5:0]      line_length,
    output logic [7:0]      read_data
);

    localparam int unsigned ADDR_W = $clog2(LINE_DEPTH);
    localparam int unsigned POS_W  = $clog2(LINE_DEPTH + 1);
    localparam int unsigned CMP_W  = (POS_W > 5) ? POS_W : 5;
    localparam int unsigned LEN_W  = (POS_W > LEN_PORT_W) ? POS_W : LEN_PORT_W;

    logic [1:0]       echo_mode_reg;
    logic [POS_W-1:0] wpos_reg, wpos_next;
    logic [POS_W-1:0] clen_reg, clen_next;
    logic             rdy_reg, rdy_next;
    logic             s1_valid_reg, s1_valid_next;
    out_job_t         s1_job_reg, job_next;

    logic             in_acc;
    logic             load_ready;
    logic             ram_we, ram_re;
    logic [7:0]       up_char;
    logic [CMP_W-1:0] idx_ext;
    logic [1:0]       n_echo;
    logic [2:0][7:0]  echo_bytes;
    logic [LEN_W-1:0] clen_ext;
    logic [7:0]       ram_q;

    assign in_ready = !s1_valid_reg || load_ready;
    assign in_acc   = in_valid && in_ready;
    assign up_char  = to_upper(rx_byte);
    assign idx_ext  = CMP_W'(read_index);

    always_comb
    begin
        wpos_next  = wpos_reg;
        clen_next  = clen_reg;
        rdy_next   = rdy_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        n_echo     = 2'd0;
        echo_bytes = '0;
        job_next   = '0;
        if (in_acc)
        begin
            unique case (kind)
                KIND_BYTE:
                begin
                    priority if (wpos_reg == POS_W'(LINE_DEPTH))
                    begin
                        // Full line: any byte is dropped together with the line.
                        wpos_next  = '0;
                        n_echo     = 2'd3;
                        echo_bytes = {CH_LF, CH_CR, CH_BEL};
                    end
                    else if (is_printable(rx_byte))
                    begin
                        ram_we        = 1'b1;
                        wpos_next     = wpos_reg + 1'b1;
                        n_echo        = 2'd1;
                        echo_bytes[0] = up_char;
                    end
                    else if (rx_byte == CH_BS)
                    begin
                        if (wpos_reg != '0)
                        begin
                            wpos_next  = wpos_reg - 1'b1;
                            n_echo     = 2'd3;
                            echo_bytes = {CH_BS, CH_SPACE, CH_BS};
                        end
                    end
                    else if (rx_byte == CH_CR)
                    begin
                        if (wpos_reg != '0)
                        begin
                            clen_next     = wpos_reg;
                            rdy_next      = 1'b1;
                            wpos_next     = '0;
                            n_echo        = 2'd2;
                            echo_bytes[0] = CH_LF;
                            echo_bytes[1] = CH_CR;
                        end
                    end
                    else
                    begin
                        n_echo = 2'd0;
                    end
                end
                KIND_READ:
                begin
                    ram_re            = 1'b1;
                    job_next.read_hit = (idx_ext < CMP_W'(clen_reg));
                end
                KIND_CLEAR:
                begin
                    rdy_next = 1'b0;
                end
                default:
                begin
                    rdy_next = rdy_reg;
                end
            endcase
        end
        if ((echo_mode_reg == 2'd0) && (n_echo != 2'd0))
        begin
            job_next.tx_en = 1'b1;
            job_next.cnt   = n_echo;
            job_next.echo  = echo_bytes;
        end
        else
        begin
            job_next.tx_en = 1'b0;
            job_next.cnt   = 2'd1;
        end
        clen_ext             = LEN_W'(clen_next);
        job_next.line_ready  = rdy_next;
        job_next.line_length = clen_ext[LEN_PORT_W-1:0];
    end

    // The pipeline register moves on whenever the output register can take its job.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (load_ready)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_mode_reg <= 2'd0;
            wpos_reg      <= '0;
            clen_reg      <= '0;
            rdy_reg       <= 1'b0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                echo_mode_reg <= cfg_wdata;
            end
            wpos_reg     <= wpos_next;
            clen_reg     <= clen_next;
            rdy_reg      <= rdy_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_job_reg <= job_next;
        end
    end

    // A read accepted after a write to the same entry sees the new data,
    // since only one word enters per cycle; the read data holds while the pipeline stalls.
    sle_ram #(
        .WIDTH (8),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wpos_reg[ADDR_W-1:0]),
        .wdata (up_char),
        .re    (ram_re),
        .raddr (idx_ext[ADDR_W-1:0]),
        .rdata (ram_q)
    );

    sle_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_valid  (s1_valid_reg),
        .load_ready  (load_ready),
        .load_job    (s1_job_reg),
        .ram_q       (ram_q),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .tx_valid    (tx_valid),
        .tx_byte     (tx_byte),
        .last        (last),
        .line_ready  (line_ready),
        .line_length (line_length),
        .read_data   (read_data)
    );

endmodule

`default_nettype wire

>>> test/serial_line_editor_echo_test.sv
// Self-checking testbench for serial_line_editor_echo: drives input words with random gaps,
// predicts every echo/status word from its own line model and compares them in order.
// Depends on sle_pkg and the serial_line_editor_echo RTL only.

module serial_line_editor_echo_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sle_pkg::*;

    localparam int          LINE_DEPTH    = 32;
    localparam int          CYCLE_LIMIT   = 300000;
    localparam int          STARVE_CYCLES = 120;
    localparam logic [1:0]  KIND_UNUSED   = 2'd3;
    localparam logic [1:0]  ECHO_ON       = 2'd0;
    localparam logic [1:0]  ECHO_QUIET_LO = 2'd1;
    localparam logic [1:0]  ECHO_QUIET_HI = 2'd2;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] rx_byte;
        logic [4:0] read_index;
    } key_t;

    typedef struct {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       last;
        logic       line_ready;
        logic [5:0] line_length;
        logic [7:0] read_data;
    } echo_word_t;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       cfg_we     = 1'b0;
    logic [1:0] cfg_wdata  = 2'd0;
    logic       in_valid   = 1'b0;
    logic       in_ready;
    logic [1:0] kind       = 2'd0;
    logic [7:0] rx_byte    = 8'd0;
    logic [4:0] read_index = 5'd0;
    logic       out_valid;
    logic       out_ready  = 1'b0;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       last;
    logic       line_ready;
    logic [5:0] line_length;
    logic [7:0] read_data;

    serial_line_editor_echo #(.LINE_DEPTH(LINE_DEPTH)) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .rx_byte    (rx_byte),
        .read_index (read_index),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .tx_valid   (tx_valid),
        .tx_byte    (tx_byte),
        .last       (last),
        .line_ready (line_ready),
        .line_length(line_length),
        .read_data  (read_data)
    );

    always #5 clk = ~clk;

    key_t       keys_to_send[$];
    echo_word_t echo_words_due[$];

    // Line model state.
    logic [7:0] model_store[LINE_DEPTH];
    int         model_pos    = 0;
    logic [5:0] model_len    = '0;
    logic       model_ready  = 1'b0;
    logic [1:0] model_echo   = ECHO_ON;

    logic       in_fire      = 1'b0;
    bit         idle_on      = 1'b1;
    bit         starve_req   = 1'b0;
    bit         starve_done  = 1'b0;
    int         gap_left     = 0;
    int         stall_left   = 0;
    int         cycle_count  = 0;
    int         mismatches   = 0;
    int         keys_taken   = 0;
    int         words_seen   = 0;
    int         lines_ended  = 0;
    int         overflows    = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    function automatic void due(input logic v, input logic [7:0] b, input logic l,
                                input logic [7:0] rd);
        echo_word_t w;
        w.tx_valid    = v;
        w.tx_byte     = b;
        w.last        = l;
        w.line_ready  = model_ready;
        w.line_length = model_len;
        w.read_data   = rd;
        echo_words_due.push_back(w);
    endfunction

    // Updates the line model for one accepted word and queues the words it must produce.
    function automatic void edit_line(input key_t k);
        logic [7:0] echo[3];
        logic [7:0] c;
        int         n;
        int         i;
        n = 0;
        if (k.kind == KIND_READ) begin
            due(1'b0, 8'h00, 1'b1,
                (6'(k.read_index) < model_len) ? model_store[k.read_index] : 8'h00);
            return;
        end
        if (k.kind != KIND_BYTE) begin
            if (k.kind == KIND_CLEAR)
                model_ready = 1'b0;
            due(1'b0, 8'h00, 1'b1, 8'h00);
            return;
        end
        if (model_pos >= LINE_DEPTH) begin
            // A full store rejects any byte and throws the line away.
            echo = '{CH_BEL, CH_CR, CH_LF};
            n = 3;
            model_pos = 0;
            overflows++;
        end else if (k.rx_byte >= CH_SPACE && k.rx_byte <= CH_TILDE) begin
            c = k.rx_byte;
            if (c >= CH_LOW_A && c <= CH_LOW_Z)
                c = c - CASE_OFS;
            model_store[model_pos] = c;
            model_pos++;
            echo[0] = c;
            n = 1;
        end else if (k.rx_byte == CH_BS) begin
            if (model_pos != 0) begin
                model_pos--;
                echo = '{CH_BS, CH_SPACE, CH_BS};
                n = 3;
            end
        end else if (k.rx_byte == CH_CR) begin
            if (model_pos != 0) begin
                model_len = model_pos[5:0];
                model_ready = 1'b1;
                model_pos = 0;
                echo[0] = CH_LF;
                echo[1] = CH_CR;
                n = 2;
                lines_ended++;
            end
        end
        if (model_echo != ECHO_ON || n == 0)
            due(1'b0, 8'h00, 1'b1, 8'h00);
        else
            for (i = 0; i < n; i++)
                due(1'b1, echo[i], i == n - 1, 8'h00);
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Monitor: checks result words and feeds accepted input words to the model.
    always @(posedge clk) begin
        echo_word_t want;
        key_t       k;
        in_fire <= in_valid && in_ready;
        if (rst_n) begin
            if (cfg_we)
                model_echo = cfg_wdata;
            if (out_valid && out_ready) begin
                words_seen++;
                if (echo_words_due.size() == 0) begin
                    $display("%0t: unexpected word expected none actual tx_valid %0b tx_byte %0h",
                             $time, tx_valid, tx_byte);
                    mismatches++;
                end else begin
                    want = echo_words_due.pop_front();
                    check_field("tx_valid", 32'(want.tx_valid), 32'(tx_valid));
                    check_field("tx_byte", 32'(want.tx_byte), 32'(tx_byte));
                    check_field("last", 32'(want.last), 32'(last));
                    check_field("line_ready", 32'(want.line_ready), 32'(line_ready));
                    check_field("line_length", 32'(want.line_length), 32'(line_length));
                    check_field("read_data", 32'(want.read_data), 32'(read_data));
                end
            end
            if (in_valid && in_ready) begin
                k.kind       = kind;
                k.rx_byte    = rx_byte;
                k.read_index = read_index;
                keys_taken++;
                edit_line(k);
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Sender: holds a word until it is taken, then waits out a random gap.
    always @(negedge clk) begin
        logic next_valid;
        key_t k;
        next_valid = in_valid;
        if (rst_n && !(in_valid && !in_fire)) begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (keys_to_send.size() != 0) begin
                k = keys_to_send.pop_front();
                kind       <= k.kind;
                rx_byte    <= k.rx_byte;
                read_index <= k.read_index;
                next_valid = 1'b1;
                gap_left   = pick_gap();
            end
        end
        in_valid <= next_valid;
    end

    // Receiver: random stalls, plus one long hold-off on request.
    always @(negedge clk) begin
        logic next_ready;
        next_ready = 1'b1;
        if (starve_req && !starve_done) begin
            stall_left  = STARVE_CYCLES;
            starve_done = 1'b1;
        end
        if (stall_left > 0) begin
            next_ready = 1'b0;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 99) < 30) begin
            next_ready = 1'b0;
            stall_left = pick_gap();
        end
        out_ready <= next_ready;
    end

    function automatic void queue_key(input logic [1:0] k, input logic [7:0] b,
                                      input logic [4:0] idx);
        key_t item;
        item.kind       = k;
        item.rx_byte    = b;
        item.read_index = idx;
        keys_to_send.push_back(item);
    endfunction

    function automatic logic [7:0] rand_char();
        if ($urandom_range(0, 9) < 6)
            return 8'($urandom_range(CH_LOW_A, CH_LOW_Z));
        return 8'($urandom_range(CH_SPACE, CH_TILDE));
    endfunction

    function automatic void queue_overflow();
        int i;
        queue_key(KIND_BYTE, CH_CR, 5'($urandom_range(0, 31)));
        for (i = 0; i < LINE_DEPTH; i++)
            queue_key(KIND_BYTE, rand_char(), 5'($urandom_range(0, 31)));
        case ($urandom_range(0, 3))
            0: queue_key(KIND_BYTE, CH_CR, 5'd0);
            1: queue_key(KIND_BYTE, CH_BS, 5'd0);
            2: queue_key(KIND_BYTE, rand_char(), 5'd0);
            default: queue_key(KIND_BYTE, 8'($urandom_range(0, 255)), 5'd0);
        endcase
    endfunction

    // Nearly half whole typed lines with reads afterwards; the rest is noise.
    function automatic void queue_random(input int n, input bit with_overflow);
        int start;
        int pick;
        int len;
        int i;
        start = keys_to_send.size();
        if (with_overflow)
            queue_overflow();
        while (keys_to_send.size() - start < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 31);
                for (i = 0; i < len; i++) begin
                    queue_key(KIND_BYTE, rand_char(), 5'($urandom_range(0, 31)));
                    if ($urandom_range(0, 9) == 0)
                        queue_key(KIND_BYTE, CH_BS, 5'($urandom_range(0, 31)));
                end
                queue_key(KIND_BYTE, CH_CR, 5'($urandom_range(0, 31)));
                for (i = $urandom_range(1, 3); i > 0; i--)
                    queue_key(KIND_READ, 8'($urandom_range(0, 255)),
                              5'($urandom_range(0, (len + 1 > 31) ? 31 : len + 1)));
                if ($urandom_range(0, 9) < 4)
                    queue_key(KIND_CLEAR, 8'($urandom_range(0, 255)),
                              5'($urandom_range(0, 31)));
            end else if (pick < 60) begin
                case ($urandom_range(0, 2))
                    0: queue_key(KIND_READ, 8'($urandom_range(0, 255)),
                                 5'($urandom_range(0, 31)));
                    1: queue_key(KIND_CLEAR, 8'($urandom_range(0, 255)),
                                 5'($urandom_range(0, 31)));
                    default: queue_key(KIND_UNUSED, 8'($urandom_range(0, 255)),
                                       5'($urandom_range(0, 31)));
                endcase
            end else if (pick < 96) begin
                queue_key(KIND_BYTE, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
            end else begin
                queue_overflow();
            end
        end
    endfunction

    task automatic set_echo_mode(input logic [1:0] mode);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Every word yields at least one result, so an empty expectation queue means idle.
    // The check runs at the rising edge, where the sender's outputs are settled.
    task automatic drain();
        while (keys_to_send.size() != 0 || in_valid || echo_words_due.size() != 0)
            @(posedge clk);
    endtask

    initial begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_echo_mode(ECHO_ON);
        queue_key(KIND_READ, 8'h00, 5'd0);
        queue_key(KIND_CLEAR, 8'h00, 5'd0);
        queue_key(KIND_UNUSED, 8'hFF, 5'd31);
        queue_key(KIND_BYTE, CH_BS, 5'd0);
        queue_key(KIND_BYTE, CH_CR, 5'd0);
        queue_key(KIND_BYTE, 8'h00, 5'd0);
        queue_key(KIND_BYTE, 8'h1F, 5'd0);
        queue_key(KIND_BYTE, 8'h7F, 5'd0);
        queue_key(KIND_BYTE, 8'hFF, 5'd31);
        queue_key(KIND_BYTE, CH_SPACE, 5'd0);
        queue_key(KIND_BYTE, CH_LOW_A, 5'd0);
        queue_key(KIND_BYTE, CH_LOW_Z, 5'd0);
        queue_key(KIND_BYTE, 8'h60, 5'd0);
        queue_key(KIND_BYTE, 8'h7B, 5'd0);
        queue_key(KIND_BYTE, CH_TILDE, 5'd0);
        queue_key(KIND_BYTE, 8'h41, 5'd0);
        queue_key(KIND_BYTE, CH_BS, 5'd0);
        queue_key(KIND_BYTE, CH_CR, 5'd0);
        queue_key(KIND_READ, 8'h00, 5'd0);
        queue_key(KIND_READ, 8'h00, 5'd5);
        queue_key(KIND_READ, 8'h00, 5'd6);
        queue_key(KIND_READ, 8'hFF, 5'd31);
        queue_key(KIND_CLEAR, 8'h00, 5'd0);
        queue_key(KIND_BYTE, CH_LF, 5'd0);
        drain();

        set_echo_mode(ECHO_QUIET_HI);
        queue_random(12, 1'b0);
        drain();

        // Back-to-back words against a long receiver hold-off.
        set_echo_mode(ECHO_ON);
        idle_on    = 1'b0;
        starve_req = 1'b1;
        queue_random(1, 1'b1);
        drain();
        idle_on = 1'b1;

        set_echo_mode(ECHO_QUIET_LO);
        queue_random(10, 1'b0);
        drain();

        set_echo_mode(ECHO_ON);
        queue_random(12, 1'b0);
        drain();

        repeat (10) @(negedge clk);
        if (echo_words_due.size() != 0) begin
            $display("%0t: leftover results expected 0 actual %0d", $time,
                     echo_words_due.size());
            mismatches++;
        end
        $display("Run covered %0d input words and %0d result words under echo modes 0, 1, 2;",
                 keys_taken, words_seen);
        $display("%0d lines completed, %0d store overflows, %0d field mismatches.",
                 lines_ended, overflows, mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
